// ----- design/fmh_pkg.sv -----
`default_nettype none

package fmh_pkg;

  localparam int ReqBits    = 2;
  localparam int StatusBits = 3;

  localparam logic [ReqBits-1:0] REQ_TRY    = 2'd0;
  localparam logic [ReqBits-1:0] REQ_LOCK   = 2'd1;
  localparam logic [ReqBits-1:0] REQ_UNLOCK = 2'd2;

  localparam logic [StatusBits-1:0] ST_OK        = 3'd0;
  localparam logic [StatusBits-1:0] ST_BUSY      = 3'd1;
  localparam logic [StatusBits-1:0] ST_QUEUED    = 3'd2;
  localparam logic [StatusBits-1:0] ST_RECURSIVE = 3'd3;
  localparam logic [StatusBits-1:0] ST_NOT_OWNER = 3'd4;

  typedef struct packed {
    logic deq;
    logic enq;
  } fmh_ctrl_t;

endpackage

`default_nettype wire

// ----- design/fmh_cell.sv -----
`default_nettype none

// one waiter slot; slot 0 is the head, slots shift towards it on dequeue
module fmh_cell
  import fmh_pkg::*;
#(
  parameter int IdBits = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fmh_ctrl_t         ctrl,
  input  wire logic              prev_valid,
  input  wire logic [IdBits-1:0] enq_id,
  input  wire logic              next_valid,
  input  wire logic [IdBits-1:0] next_id,
  output logic                   valid,
  output logic      [IdBits-1:0] id
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.deq) begin
      valid <= next_valid;
    end else if (ctrl.enq && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      id <= next_id;
    end else if (ctrl.enq && !valid && prev_valid) begin
      id <= enq_id;
    end
  end

endmodule

`default_nettype wire

// ----- design/fifo_handoff_mutex_unit.sv -----
`default_nettype none

// channel | direction | handshake            | payload
// request | in        | in_valid / in_ready   | req_type, thread_id
// result  | out       | out_valid / out_ready | status, locked, owner_id, wake_valid,
//         |           |                       | wake_thread
//
// One request per cycle unless stalled; its result, registered, appears the cycle after it.
// Waiters sit in a row of 2**THREAD_ID_BITS slot cells, head at slot 0, shifting on handoff.
// A request is taken while the result register is empty or being emptied in the same cycle.
// Reset clears the lock, the waiter slots and the waiting map.
module fifo_handoff_mutex_unit
  import fmh_pkg::*;
#(
  parameter int THREAD_ID_BITS = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ReqBits-1:0]        req_type,
  input  wire logic [THREAD_ID_BITS-1:0] thread_id,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [StatusBits-1:0]     status,
  output logic                           locked,
  output logic      [THREAD_ID_BITS-1:0] owner_id,
  output logic                           wake_valid,
  output logic      [THREAD_ID_BITS-1:0] wake_thread
);

  localparam int NumThreads = 1 << THREAD_ID_BITS;

  logic                      held;
  logic [THREAD_ID_BITS-1:0] holder;
  logic [NumThreads-1:0]     waiting_map;

  logic                      held_next;
  logic [THREAD_ID_BITS-1:0] holder_next;
  logic [NumThreads-1:0]     waiting_map_next;
  logic [StatusBits-1:0]     status_next;
  logic                      wake_valid_next;
  logic [THREAD_ID_BITS-1:0] wake_thread_next;

  logic                      cell_valid [NumThreads];
  logic [THREAD_ID_BITS-1:0] cell_id    [NumThreads];
  fmh_ctrl_t                 ctrl;
  logic                      fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    held_next        = held;
    holder_next      = holder;
    waiting_map_next = waiting_map;
    status_next      = ST_BUSY;
    wake_valid_next  = 1'b0;
    wake_thread_next = '0;
    ctrl             = '0;
    case (req_type)
      REQ_TRY: begin
        if (!held) begin
          held_next   = 1'b1;
          holder_next = thread_id;
          status_next = ST_OK;
        end
      end
      REQ_LOCK: begin
        if (!held) begin
          held_next   = 1'b1;
          holder_next = thread_id;
          status_next = ST_OK;
        end else if (holder == thread_id) begin
          status_next = ST_RECURSIVE;
        end else begin
          status_next = ST_QUEUED;
          if (!waiting_map[thread_id] && !cell_valid[NumThreads-1]) begin
            ctrl.enq                    = fire;
            waiting_map_next[thread_id] = 1'b1;
          end
        end
      end
      REQ_UNLOCK: begin
        if (!held || holder != thread_id) begin
          status_next = ST_NOT_OWNER;
        end else if (cell_valid[0]) begin
          ctrl.deq                     = fire;
          waiting_map_next[cell_id[0]] = 1'b0;
          holder_next                  = cell_id[0];
          wake_valid_next              = 1'b1;
          wake_thread_next             = cell_id[0];
          status_next                  = ST_OK;
        end else begin
          held_next   = 1'b0;
          holder_next = '0;
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_BUSY;
      end
    endcase
  end

  for (genvar i = 0; i < NumThreads; i++) begin : g_cell
    logic                      prev_v;
    logic                      next_v;
    logic [THREAD_ID_BITS-1:0] next_i;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end
    if (i == NumThreads - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_i = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_i = cell_id[i+1];
    end
    fmh_cell #(
      .IdBits(THREAD_ID_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_valid(prev_v),
      .enq_id    (thread_id),
      .next_valid(next_v),
      .next_id   (next_i),
      .valid     (cell_valid[i]),
      .id        (cell_id[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      holder      <= '0;
      waiting_map <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        held        <= held_next;
        holder      <= holder_next;
        waiting_map <= waiting_map_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= status_next;
      locked      <= held_next;
      owner_id    <= holder_next;
      wake_valid  <= wake_valid_next;
      wake_thread <= wake_thread_next;
    end
  end

  logic [NumThreads-1:0] cell_valid_vec;
  always_comb begin
    for (int k = 0; k < NumThreads; k++) begin
      cell_valid_vec[k] = cell_valid[k];
    end
  end

  a_wake_hands_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_valid |-> status == ST_OK && locked)
    else $error("handoff result without lock held");

  a_free_no_owner: assert property (@(posedge clk) disable iff (rst)
    out_valid && !locked |-> owner_id == '0)
    else $error("free lock reports an owner");

  a_waiters_need_holder: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] |-> held)
    else $error("waiters queued on a free lock");

  a_holder_not_waiting: assert property (@(posedge clk) disable iff (rst)
    held |-> !waiting_map[holder])
    else $error("holder still marked waiting");

  a_map_matches_queue: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid_vec) == $countones(waiting_map))
    else $error("waiting map and queue disagree");

endmodule

`default_nettype wire

// ----- tb/fifo_handoff_mutex_unit_test.sv -----
`default_nettype none

module fifo_handoff_mutex_unit_test;
  import fmh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TidBits    = 4;
  localparam int Threads    = 1 << TidBits;
  localparam int RandReqs   = 1630;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 90;

  // request code that changes no lock state and is answered with busy status
  localparam logic [ReqBits-1:0] REQ_IDLE = 2'd3;

  typedef struct packed {
    logic [ReqBits-1:0] req;
    logic [TidBits-1:0] tid;
  } lock_req_t;

  typedef struct packed {
    logic                          held;
    logic [TidBits-1:0]            holder;
    logic [Threads-1:0][TidBits-1:0] slots;
    logic [TidBits-1:0]            head;
    logic [TidBits-1:0]            tail;
    logic [TidBits:0]              count;
    logic [Threads-1:0]            waiting;
  } lock_state_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic                  locked;
    logic [TidBits-1:0]    owner;
    logic                  wake_valid;
    logic [TidBits-1:0]    wake_thread;
  } lock_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ReqBits-1:0]    req_type = '0;
  logic [TidBits-1:0]    thread_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [StatusBits-1:0] status;
  logic                  locked;
  logic [TidBits-1:0]    owner_id;
  logic                  wake_valid;
  logic [TidBits-1:0]    wake_thread;

  fifo_handoff_mutex_unit #(
    .THREAD_ID_BITS(TidBits)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .thread_id  (thread_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .locked     (locked),
    .owner_id   (owner_id),
    .wake_valid (wake_valid),
    .wake_thread(wake_thread)
  );

  always #1 clk = ~clk;

  lock_req_t    pending_reqs[$];
  lock_result_t expected_results[$];
  lock_state_t  plan_lock;
  lock_state_t  dut_lock;

  int total_reqs;
  int lock_reqs;
  int issued;
  int accepted_reqs;
  int results_seen;
  int mismatches;
  int handoffs;
  int deepest_queue;
  int cycles;
  int status_seen[8];

  int gap_left;
  int burst_left;
  int hold_left;
  int holds_done;
  int mode;
  int mode_left;
  logic [7:0] stall_pat;

  lock_req_t    cur_req;
  lock_result_t got;
  lock_result_t want;

  function automatic lock_result_t next_lock_result(inout lock_state_t s,
                                                    input logic [ReqBits-1:0] req,
                                                    input logic [TidBits-1:0] tid);
    lock_result_t r;
    logic [TidBits-1:0] next_tid;
    r = '0;
    r.status = ST_BUSY;
    case (req)
      REQ_TRY: begin
        if (!s.held) begin
          s.held = 1'b1;
          s.holder = tid;
          r.status = ST_OK;
        end
      end
      REQ_LOCK: begin
        if (!s.held) begin
          s.held = 1'b1;
          s.holder = tid;
          r.status = ST_OK;
        end else if (s.holder == tid) begin
          r.status = ST_RECURSIVE;
        end else begin
          if (!s.waiting[tid] && s.count < Threads) begin
            s.slots[s.tail] = tid;
            s.tail = s.tail + 1'b1;
            s.count = s.count + 1'b1;
            s.waiting[tid] = 1'b1;
          end
          r.status = ST_QUEUED;
        end
      end
      REQ_UNLOCK: begin
        if (!s.held || s.holder != tid) begin
          r.status = ST_NOT_OWNER;
        end else if (s.count != 0) begin
          next_tid = s.slots[s.head];
          s.head = s.head + 1'b1;
          s.count = s.count - 1'b1;
          s.waiting[next_tid] = 1'b0;
          s.holder = next_tid;
          r.wake_valid = 1'b1;
          r.wake_thread = next_tid;
          r.status = ST_OK;
        end else begin
          s.held = 1'b0;
          s.holder = '0;
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.locked = s.held;
    r.owner = s.held ? s.holder : '0;
    return r;
  endfunction

  task automatic plan(input logic [ReqBits-1:0] req, input logic [TidBits-1:0] tid);
    lock_req_t item;
    item.req = req;
    item.tid = tid;
    pending_reqs.push_back(item);
    void'(next_lock_result(plan_lock, req, tid));
    if (req != REQ_IDLE) lock_reqs++;
  endtask

  // every thread piles onto a held lock, then ownership is passed down the queue
  task automatic plan_convoy();
    int start;
    start = $urandom_range(0, Threads - 1);
    if (!plan_lock.held) plan(REQ_LOCK, TidBits'($urandom_range(0, Threads - 1)));
    for (int i = 0; i < Threads; i++) begin
      plan(REQ_LOCK, TidBits'(start + i));
    end
    for (int i = 0; i < Threads + 2; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        plan(ReqBits'($urandom_range(0, 3)), TidBits'($urandom_range(0, Threads - 1)));
      end
      if (plan_lock.held) plan(REQ_UNLOCK, plan_lock.holder);
    end
  endtask

  task automatic plan_random();
    int r;
    logic [TidBits-1:0] tid;
    r = $urandom_range(0, 99);
    tid = TidBits'($urandom_range(0, Threads - 1));
    if (r < 30) begin
      plan(REQ_UNLOCK, plan_lock.held ? plan_lock.holder : tid);
    end else if (r < 60) begin
      plan(REQ_LOCK, tid);
    end else if (r < 72) begin
      plan(REQ_TRY, tid);
    end else if (r < 82) begin
      plan(REQ_UNLOCK, tid);
    end else if (r < 87) begin
      plan(REQ_IDLE, tid);
    end else begin
      plan($urandom_range(0, 1) ? REQ_LOCK : REQ_TRY, plan_lock.holder);
    end
  endtask

  initial begin
    plan_lock = '0;
    dut_lock = '0;

    plan(REQ_UNLOCK, 4'd0);
    plan(REQ_TRY, 4'd15);
    plan(REQ_TRY, 4'd15);
    plan(REQ_TRY, 4'd0);
    plan(REQ_LOCK, 4'd15);
    plan(REQ_LOCK, 4'd0);
    plan(REQ_LOCK, 4'd0);
    plan(REQ_LOCK, 4'd5);
    plan(REQ_UNLOCK, 4'd0);
    plan(REQ_UNLOCK, 4'd3);
    plan(REQ_IDLE, 4'd15);
    plan(REQ_UNLOCK, 4'd15);
    plan(REQ_UNLOCK, 4'd0);
    plan(REQ_UNLOCK, 4'd5);
    plan(REQ_LOCK, 4'd0);
    plan(REQ_LOCK, 4'd10);
    plan(REQ_UNLOCK, 4'd0);
    plan(REQ_UNLOCK, 4'd10);
    plan(REQ_IDLE, 4'd0);
    plan(REQ_TRY, 4'd10);
    plan(REQ_UNLOCK, 4'd10);

    while (lock_reqs < RandReqs + 20) begin
      if ($urandom_range(0, 149) == 0) plan_convoy();
      else plan_random();
    end
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(accepted_reqs == total_reqs && expected_results.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests transferred (%0d ignored codes), %0d results checked, %0d handoffs",
             accepted_reqs, accepted_reqs - lock_reqs, results_seen, handoffs);
    $display("status mix ok/busy/queued/recursive/not-owner %0d/%0d/%0d/%0d/%0d, max waiters %0d",
             status_seen[ST_OK], status_seen[ST_BUSY], status_seen[ST_QUEUED],
             status_seen[ST_RECURSIVE], status_seen[ST_NOT_OWNER], deepest_queue);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // sender: bursts of back-to-back transfers separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (issued == accepted_reqs) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        req_type <= cur_req.req;
        thread_id <= cur_req.tid;
        in_valid <= 1'b1;
        issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: mode changes at random intervals, plus two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done == 0 ? 500 : 1200)) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
          stall_pat = 8'($urandom);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: begin
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.status = status;
        got.locked = locked;
        got.owner = owner_id;
        got.wake_valid = wake_valid;
        got.wake_thread = wake_thread;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: status %0d locked %0d owner %0d wake %0d/%0d",
                     got.status, got.locked, got.owner, got.wake_valid, got.wake_thread);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.locked !== want.locked ||
              got.owner !== want.owner || got.wake_valid !== want.wake_valid ||
              got.wake_thread !== want.wake_thread) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: exp status %0d locked %0d owner %0d wake %0d/%0d",
                       results_seen, want.status, want.locked, want.owner,
                       want.wake_valid, want.wake_thread);
              $display("result %0d: got status %0d locked %0d owner %0d wake %0d/%0d",
                       results_seen, got.status, got.locked, got.owner,
                       got.wake_valid, got.wake_thread);
            end
          end
        end
        results_seen++;
        status_seen[got.status]++;
        if (got.wake_valid === 1'b1) handoffs++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(next_lock_result(dut_lock, req_type, thread_id));
        accepted_reqs++;
        if (int'(dut_lock.count) > deepest_queue) deepest_queue = int'(dut_lock.count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
